FILE: rtl/crc_hashed_flow_stats_table_assert.svh
// Assertion macros used by crc_hashed_flow_stats_table.sv.
`ifndef CRC_HASHED_FLOW_STATS_TABLE_ASSERT_SVH
`define CRC_HASHED_FLOW_STATS_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CFST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cfst assertion failed");
`define CFST_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cfst forbidden condition");
`else
`define CFST_ASSERT(lbl, clk, rst, prop)
`define CFST_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: rtl/cfst_pkg.sv
`default_nettype none

package cfst_pkg;

  localparam int MSG_BITS = 104;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_UPDATE   = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_COPY     = 3'd3;
  localparam logic [2:0] OP_AGE_TICK = 3'd4;

  localparam logic [15:0] AGE_RELOAD_RESET = 16'd30;

  typedef struct packed {
    logic [15:0] age;
    logic [47:0] in_octets;
    logic [31:0] in_pkts;
    logic [47:0] out_octets;
    logic [31:0] out_pkts;
    logic [15:0] copies;
  } entry_t;

  typedef logic [MSG_BITS-1:0][31:0] crc_cols_t;

  // Bit-serial reflected CRC-32; bit 0 of msg is the first bit on the wire.
  function automatic logic [31:0] crc_serial(input logic [MSG_BITS-1:0] msg);
    logic [31:0] c;
    logic        fb;
    c = CRC_INIT;
    for (int j = 0; j < MSG_BITS; j++) begin
      fb = c[0] ^ msg[j];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c ^ CRC_INIT;
  endfunction

  // The CRC of a fixed-length message is affine in its bits, so each message
  // bit contributes one constant column.
  function automatic crc_cols_t crc_build_cols();
    crc_cols_t   t;
    logic [31:0] z;
    z = crc_serial('0);
    for (int i = 0; i < MSG_BITS; i++) begin
      t[i] = crc_serial(MSG_BITS'(1) << i) ^ z;
    end
    return t;
  endfunction

  localparam logic [31:0] CRC_ZERO = crc_serial('0);
  localparam crc_cols_t   CRC_COLS = crc_build_cols();

endpackage

`default_nettype wire

FILE: rtl/crc_hashed_flow_stats_table.sv
// Direct-mapped flow statistics table indexed by a CRC-32 of the flow 5-tuple.
// Input beats arrive on s_tvalid/s_tready/s_tdata with the operation in
// s_tuser. Each beat produces exactly one result beat on m_tvalid/m_tready/
// m_tdata. The cfg channel writes the age reload value; it is always ready
// and should only be used while the table is idle.
// A packet operation hashes and reads the bucket in the accept cycle; in
// ST_MODIFY, once the output register is free, the entry is modified,
// written back and loaded into the output register. Each item does one
// bucket read-modify-write. An age tick walks every bucket at one per
// cycle, and its result beat follows the walk.
// After reset the table is cleared one bucket per cycle, and s_tready stays
// low until every bucket is cleared.
// The result sits in an output register; when the receiver stalls, the next
// item is still taken, and its result waits until the register is free.
`default_nettype none
`include "crc_hashed_flow_stats_table_assert.svh"

module crc_hashed_flow_stats_table #(
  parameter int BUCKETS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // src_addr, dst_addr, src_port, dst_port, protocol, in_byte_delta,
  // in_pkt_delta, out_byte_delta, out_pkt_delta
  input  wire logic [151:0] s_tdata,
  // op
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // bucket, entry_live, age_left, total_in_bytes, total_in_pkts,
  // total_out_bytes, total_out_pkts, copy_count, expired_count, zero fill
  output logic [223:0]      m_tdata
);
  import cfst_pkg::*;

  localparam int IW = $clog2(BUCKETS);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_AGE    = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [15:0]   age_reload;
  logic [IW:0]   cnt;
  logic          p_vld;
  logic [IW-1:0] p_addr;
  logic [12:0]   expired;

  logic [2:0]    op_r;
  logic [IW-1:0] idx_r;
  logic [15:0]   ib_r;
  logic [7:0]    ip_r;
  logic [15:0]   ob_r;
  logic [7:0]    opk_r;

  entry_t        mem [BUCKETS];
  entry_t        rd_data;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic [MSG_BITS-1:0] msg;
  logic [31:0]         crc;
  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                issue;
  logic                walk_done;
  logic                expire;
  entry_t              modified;
  entry_t              aged;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign issue     = !cnt[IW];
  assign walk_done = cnt[IW] && !p_vld;
  assign out_load  = out_free && ((state == ST_MODIFY) || (state == ST_AGE && walk_done));

  assign msg = s_tdata[MSG_BITS-1:0];

  always_comb begin
    crc = CRC_ZERO;
    for (int i = 0; i < MSG_BITS; i++) begin
      if (msg[i]) begin
        crc = crc ^ CRC_COLS[i];
      end
    end
  end

  always_comb begin
    modified = rd_data;
    unique case (op_r)
      OP_CREATE: begin
        modified.age        = age_reload;
        modified.in_octets  = 48'(ib_r);
        modified.in_pkts    = 32'(ip_r);
        modified.out_octets = 48'(ob_r);
        modified.out_pkts   = 32'(opk_r);
        modified.copies     = '0;
      end
      OP_UPDATE: begin
        modified.age        = age_reload;
        modified.in_octets  = rd_data.in_octets + 48'(ib_r);
        modified.in_pkts    = rd_data.in_pkts + 32'(ip_r);
        modified.out_octets = rd_data.out_octets + 48'(ob_r);
        modified.out_pkts   = rd_data.out_pkts + 32'(opk_r);
      end
      OP_DELETE: modified = '0;
      OP_COPY:   modified.copies = rd_data.copies + 16'd1;
      default:   modified = rd_data;
    endcase
  end

  always_comb begin
    aged   = rd_data;
    expire = 1'b0;
    if (rd_data.age == 16'd1) begin
      aged   = '0;
      expire = 1'b1;
    end else if (rd_data.age != 16'd0) begin
      aged.age = rd_data.age - 16'd1;
    end
  end

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = crc[IW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = modified;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = '0;
        if (cnt[IW-1:0] == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_AGE_TICK) begin
            state_next = ST_AGE;
          end else begin
            mem_re     = 1'b1;
            state_next = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        if (out_free) begin
          mem_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_AGE: begin
        mem_re    = issue;
        mem_raddr = cnt[IW-1:0];
        mem_we    = p_vld;
        mem_waddr = p_addr;
        mem_wdata = aged;
        if (walk_done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      p_vld      <= 1'b0;
      expired    <= '0;
      age_reload <= AGE_RELOAD_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        age_reload <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= (cnt[IW-1:0] == '1) ? '0 : cnt + 1'b1;
        end
        ST_IDLE: begin
          cnt     <= '0;
          p_vld   <= 1'b0;
          expired <= '0;
        end
        ST_MODIFY: ;
        ST_AGE: begin
          cnt     <= cnt + (IW + 1)'(issue);
          p_vld   <= issue;
          expired <= expired + 13'(p_vld && expire);
        end
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= cnt[IW-1:0];
    if (accept) begin
      op_r  <= s_tuser;
      idx_r <= crc[IW-1:0];
      ib_r  <= s_tdata[119:104];
      ip_r  <= s_tdata[127:120];
      ob_r  <= s_tdata[143:128];
      opk_r <= s_tdata[151:144];
    end
    if (state == ST_MODIFY && out_free) begin
      m_tdata <= {6'd0, 13'd0, modified.copies, modified.out_pkts, modified.out_octets,
                  modified.in_pkts, modified.in_octets, modified.age,
                  (modified.age != 16'd0), 12'(idx_r)};
    end else if (state == ST_AGE && walk_done && out_free) begin
      m_tdata <= {6'd0, expired, 205'd0};
    end
  end

  `CFST_ASSERT(a_pkt_to_modify, clk, rst,
    (accept && s_tuser != OP_AGE_TICK) |=> (state == ST_MODIFY))
  `CFST_ASSERT(a_modify_result, clk, rst,
    (state == ST_MODIFY && out_free) |=> (m_tvalid && state == ST_IDLE))
  `CFST_ASSERT(a_walk_trails, clk, rst,
    (state == ST_AGE && p_vld) |-> (cnt == (IW + 1)'(p_addr) + 1'b1))
  `CFST_NEVER(a_no_accept_busy, clk, rst,
    s_tready && (p_vld || state != ST_IDLE))

endmodule

`default_nettype wire
